// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pmss_pkg.sv -----
// ----------------------------------------------------------------------------
// Priority message slot store package
// Shared sizes, command and status codes, and interface structs.
// ----------------------------------------------------------------------------
package pmss_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam int CMD_W  = 2;
    localparam int KEY_W  = 16;
    localparam int SEL_W  = 4;
    localparam int STAT_W = 2;
    localparam int IDX_W  = 4;
    localparam int ENT_W  = 5;
    localparam int MAG_W  = 15;

    localparam logic [MAG_W-1:0] INF_MAG = 15'h7C00;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [KEY_W-1:0] key;
        logic [SEL_W-1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  slot_index;
        logic [ENT_W-1:0]  entry_count;
    } t_result;

    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [KEY_W-1:0]  wr_data;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
    } t_mem_req;

endpackage

// ----- rtl/core/pmss_key_mem.sv -----
// ----------------------------------------------------------------------------
// Key memory
// One write port and one registered read port holding the slot keys.
// ----------------------------------------------------------------------------
module pmss_key_mem (
    input  logic                             i_clk,
    input  pmss_pkg::t_mem_req               i_req,
    output logic [pmss_pkg::KEY_W-1:0]       o_rd_data
);

    logic [pmss_pkg::KEY_W-1:0] r_mem [pmss_pkg::SLOTS];
    logic [pmss_pkg::KEY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/pmss_ctrl.sv -----
// ----------------------------------------------------------------------------
// Slot store controller
// Command sequencer, valid bits, entry count and the slot scans for add/get.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmss_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    output logic                         o_cmd_ready,
    input  pmss_pkg::t_cmd               i_cmd,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output pmss_pkg::t_result            o_res,
    output pmss_pkg::t_mem_req           o_mem_req,
    input  logic [pmss_pkg::KEY_W-1:0]   i_rd_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADD  = 4'b0010,
        S_GET  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state                           r_state, n_state;
    logic [pmss_pkg::SLOTS-1:0]       r_valid, n_valid;
    logic [pmss_pkg::CNT_W-1:0]       r_count, n_count;
    logic [pmss_pkg::SLOT_W-1:0]      r_scan_idx, n_scan_idx;
    logic                             r_issue_done, n_issue_done;
    logic                             r_pipe_vld, n_pipe_vld;
    logic [pmss_pkg::SLOT_W-1:0]      r_pipe_idx, n_pipe_idx;
    logic                             r_found, n_found;
    logic [pmss_pkg::MAG_W-1:0]       r_best_mag, n_best_mag;
    logic [pmss_pkg::SLOT_W-1:0]      r_best_idx, n_best_idx;
    logic [pmss_pkg::KEY_W-1:0]       r_key, n_key;
    logic [pmss_pkg::STAT_W-1:0]      r_res_status, n_res_status;
    logic [pmss_pkg::SLOT_W-1:0]      r_res_idx, n_res_idx;

    logic [pmss_pkg::MAG_W-1:0]       w_mag;
    logic                             w_hit;
    logic                             w_last;
    logic [pmss_pkg::SLOT_W-1:0]      w_sel;
    logic                             w_sel_ok;
    pmss_pkg::t_mem_req               w_req;

    assign w_mag    = i_rd_data[pmss_pkg::MAG_W-1:0];
    assign w_hit    = r_pipe_vld && r_valid[r_pipe_idx] && (w_mag <= pmss_pkg::INF_MAG)
                      && (w_mag >= r_best_mag);
    assign w_last   = r_pipe_vld && (r_pipe_idx == pmss_pkg::SLOT_W'(pmss_pkg::SLOTS - 1));
    assign w_sel    = pmss_pkg::SLOT_W'(i_cmd.slot);
    assign w_sel_ok = (32'(i_cmd.slot) < 32'(pmss_pkg::SLOTS));

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_count      = r_count;
        n_scan_idx   = r_scan_idx;
        n_issue_done = r_issue_done;
        n_pipe_vld   = 1'b0;
        n_pipe_idx   = r_scan_idx;
        n_found      = r_found;
        n_best_mag   = r_best_mag;
        n_best_idx   = r_best_idx;
        n_key        = r_key;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        w_req        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_res_status = pmss_pkg::ST_OK;
                    n_res_idx    = '0;
                    n_state      = S_FIN;
                    unique case (i_cmd.command)
                        pmss_pkg::CMD_ADD: begin
                            if (r_count >= pmss_pkg::CNT_W'(pmss_pkg::SLOTS)) begin
                                n_res_status = pmss_pkg::ST_FULL;
                            end else begin
                                n_key      = i_cmd.key;
                                n_scan_idx = '0;
                                n_state    = S_ADD;
                            end
                        end
                        pmss_pkg::CMD_GET: begin
                            n_scan_idx   = '0;
                            n_issue_done = 1'b0;
                            n_found      = 1'b0;
                            n_best_mag   = '0;
                            n_best_idx   = '0;
                            n_state      = S_GET;
                        end
                        pmss_pkg::CMD_REMOVE: begin
                            if (w_sel_ok && r_valid[w_sel]) begin
                                n_valid[w_sel] = 1'b0;
                                n_count        = r_count - pmss_pkg::CNT_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ADD: begin
                if (!r_valid[r_scan_idx]) begin
                    w_req.wr_en         = 1'b1;
                    w_req.wr_addr       = r_scan_idx;
                    w_req.wr_data       = r_key;
                    n_valid[r_scan_idx] = 1'b1;
                    n_count             = r_count + pmss_pkg::CNT_W'(1);
                    n_res_idx           = r_scan_idx;
                    n_state             = S_FIN;
                end else begin
                    n_scan_idx = r_scan_idx + pmss_pkg::SLOT_W'(1);
                end
            end
            S_GET: begin
                // issue one read per cycle, compare the returned key in the next cycle
                if (!r_issue_done) begin
                    w_req.rd_en   = 1'b1;
                    w_req.rd_addr = r_scan_idx;
                    n_pipe_vld    = 1'b1;
                    if (r_scan_idx == pmss_pkg::SLOT_W'(pmss_pkg::SLOTS - 1)) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_scan_idx = r_scan_idx + pmss_pkg::SLOT_W'(1);
                    end
                end
                if (w_hit) begin
                    n_found    = 1'b1;
                    n_best_mag = w_mag;
                    n_best_idx = r_pipe_idx;
                end
                if (w_last) begin
                    n_state = S_FIN;
                    if (r_found || w_hit) begin
                        n_res_status = pmss_pkg::ST_OK;
                        n_res_idx    = w_hit ? r_pipe_idx : r_best_idx;
                    end else begin
                        n_res_status = pmss_pkg::ST_EMPTY;
                        n_res_idx    = '0;
                    end
                end
            end
            S_FIN: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_count      <= '0;
            r_issue_done <= 1'b0;
            r_pipe_vld   <= 1'b0;
            r_found      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_count      <= n_count;
            r_issue_done <= n_issue_done;
            r_pipe_vld   <= n_pipe_vld;
            r_found      <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_idx   <= n_scan_idx;
        r_pipe_idx   <= n_pipe_idx;
        r_best_mag   <= n_best_mag;
        r_best_idx   <= n_best_idx;
        r_key        <= n_key;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
    end

    assign o_cmd_ready           = (r_state == S_IDLE);
    assign o_res_valid           = (r_state == S_FIN);
    assign o_res.status          = r_res_status;
    assign o_res.slot_index      = pmss_pkg::IDX_W'(r_res_idx);
    assign o_res.entry_count     = pmss_pkg::ENT_W'(r_count);
    assign o_mem_req             = w_req;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n,
        r_count <= pmss_pkg::CNT_W'(pmss_pkg::SLOTS), "entry count above slot total")
    `ASSERT_ALWAYS(a_count_match, i_clk, i_rst_n,
        $countones(r_valid) == 32'(r_count), "entry count disagrees with valid bits")
    `ASSERT_IMPLY(a_wr_free, i_clk, i_rst_n, w_req.wr_en,
        !r_valid[w_req.wr_addr], "key written over an occupied slot")
    `ASSERT_ALWAYS(a_port_excl, i_clk, i_rst_n,
        !(w_req.wr_en && w_req.rd_en), "key memory read and written together")

endmodule

// ----- rtl/core/priority_message_slot_store_top.sv -----
// ----------------------------------------------------------------------------
// Priority message slot store
// Slot table with valid bits and half-float priority keys; add, get, remove.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (i_in_valid / o_in_ready) carries command, key and slot.
//   Result channel (o_out_valid / i_out_ready) returns status, slot index and
//   the entry count after the command; every command gives one result.
//   Keys live in a one-port-write, registered-read memory; valid bits and the
//   entry count are in flip-flops.
//   Add scans from slot 0 up to the first free slot; get walks every slot
//   through the memory read port, one slot per cycle; remove, unused codes
//   and add to a full table need no scan.
//   One command is in work at a time; the next is taken once the result has
//   moved to the output register and the controller is back in idle.
//   Reset empties the table and clears the count; no clearing pass runs.
//   A stalled receiver holds the output register; one further command can be
//   taken and completed, then the block waits until the output drains.
// ----------------------------------------------------------------------------
module priority_message_slot_store_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [pmss_pkg::CMD_W-1:0]        i_command,
    input  logic [pmss_pkg::KEY_W-1:0]        i_key,
    input  logic [pmss_pkg::SEL_W-1:0]        i_slot,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [pmss_pkg::STAT_W-1:0]       o_status,
    output logic [pmss_pkg::IDX_W-1:0]        o_slot_index,
    output logic [pmss_pkg::ENT_W-1:0]        o_entry_count
);

    pmss_pkg::t_cmd                 w_cmd;
    pmss_pkg::t_result              w_res;
    pmss_pkg::t_mem_req             w_mem_req;
    logic [pmss_pkg::KEY_W-1:0]     w_rd_data;
    logic                           w_res_valid;
    logic                           w_res_ready;

    logic                           r_out_vld;
    pmss_pkg::t_result              r_out;

    assign w_cmd.command = i_command;
    assign w_cmd.key     = i_key;
    assign w_cmd.slot    = i_slot;

    pmss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_in_valid),
        .o_cmd_ready (o_in_ready),
        .i_cmd       (w_cmd),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_mem_req   (w_mem_req),
        .i_rd_data   (w_rd_data)
    );

    pmss_key_mem u_key_mem (
        .i_clk     (i_clk),
        .i_req     (w_mem_req),
        .o_rd_data (w_rd_data)
    );

    assign w_res_ready = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_ready) begin
            r_out_vld <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_out.status;
    assign o_slot_index  = r_out.slot_index;
    assign o_entry_count = r_out.entry_count;

endmodule

// ----- tb/priority_message_slot_store_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority message slot store testbench
// Drives add, get, remove and unused-code commands through the valid/ready
// command channel, tracks the slot table alongside the block to predict every
// result, and checks each result transfer field by field, under random idling
// on both channels, a long receiver hold-off and a full drain of the block.
// ----------------------------------------------------------------------------
module priority_message_slot_store_top_tb;

    localparam logic [pmss_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int               CLK_HALF     = 5;
    localparam int               RESET_CYCLES = 6;
    localparam int               RANDOM_ITEMS = 1230;
    localparam int               QUIET_ITEMS  = 200;
    localparam int               HOLD_ITEM    = 400;
    localparam int               DRAIN_ITEM   = 700;
    localparam int               LONG_HOLD    = 400;
    localparam int               TAIL_CYCLES  = pmss_pkg::SLOTS + 8;
    localparam int               MAX_PRINTS   = 40;

    class slot_table_tracker;
        bit                          occupied [pmss_pkg::SLOTS];
        logic [pmss_pkg::KEY_W-1:0]  stored_key [pmss_pkg::SLOTS];
        int unsigned                 live_entries;
        pmss_pkg::t_result           expected_results [$];
        int unsigned                 error_count;

        function new();
            foreach (occupied[i]) begin
                occupied[i]   = 1'b0;
                stored_key[i] = '0;
            end
            live_entries = 0;
            error_count  = 0;
        endfunction

        task report(input string what);
            if (error_count < MAX_PRINTS) begin
                $display("ERROR at %0t ns: %s", $time, what);
            end
            error_count++;
        endtask

        function int pending();
            return expected_results.size();
        endfunction

        function logic [pmss_pkg::SEL_W-1:0] pick_occupied();
            int start;
            start = $urandom_range(0, pmss_pkg::SLOTS - 1);
            for (int k = 0; k < pmss_pkg::SLOTS; k++) begin
                if (occupied[(start + k) % pmss_pkg::SLOTS]) begin
                    return pmss_pkg::SEL_W'((start + k) % pmss_pkg::SLOTS);
                end
            end
            return pmss_pkg::SEL_W'(start);
        endfunction

        function void take_command(input pmss_pkg::t_cmd c);
            pmss_pkg::t_result           r;
            bit                          found;
            logic [pmss_pkg::MAG_W-1:0]  best_mag;
            logic [pmss_pkg::MAG_W-1:0]  mag;
            r.status     = pmss_pkg::ST_OK;
            r.slot_index = '0;
            case (c.command)
                pmss_pkg::CMD_ADD: begin
                    r.status = pmss_pkg::ST_FULL;
                    if (live_entries < pmss_pkg::SLOTS) begin
                        for (int i = 0; i < pmss_pkg::SLOTS; i++) begin
                            if (!occupied[i] && r.status == pmss_pkg::ST_FULL) begin
                                occupied[i]   = 1'b1;
                                stored_key[i] = c.key;
                                live_entries++;
                                r.status      = pmss_pkg::ST_OK;
                                r.slot_index  = pmss_pkg::IDX_W'(i);
                            end
                        end
                    end
                end
                pmss_pkg::CMD_GET: begin
                    found    = 1'b0;
                    best_mag = '0;
                    for (int i = 0; i < pmss_pkg::SLOTS; i++) begin
                        mag = stored_key[i][pmss_pkg::MAG_W-1:0];
                        if (occupied[i] && mag <= pmss_pkg::INF_MAG && mag >= best_mag) begin
                            best_mag     = mag;
                            r.slot_index = pmss_pkg::IDX_W'(i);
                            found        = 1'b1;
                        end
                    end
                    if (!found) begin
                        r.status     = pmss_pkg::ST_EMPTY;
                        r.slot_index = '0;
                    end
                end
                pmss_pkg::CMD_REMOVE: begin
                    if (c.slot < pmss_pkg::SLOTS && occupied[c.slot]) begin
                        occupied[c.slot] = 1'b0;
                        if (live_entries > 0) begin
                            live_entries--;
                        end
                    end
                end
                default: begin
                end
            endcase
            r.entry_count = live_entries[pmss_pkg::ENT_W-1:0];
            expected_results.push_back(r);
        endfunction

        task check_result(input pmss_pkg::t_result got);
            pmss_pkg::t_result want;
            if (expected_results.size() == 0) begin
                report($sformatf("result with nothing pending: status %0d slot %0d count %0d",
                                 got.status, got.slot_index, got.entry_count));
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status) begin
                    report($sformatf("status %0d, expected %0d", got.status, want.status));
                end
                if (got.slot_index !== want.slot_index) begin
                    report($sformatf("slot_index %0d, expected %0d",
                                     got.slot_index, want.slot_index));
                end
                if (got.entry_count !== want.entry_count) begin
                    report($sformatf("entry_count %0d, expected %0d",
                                     got.entry_count, want.entry_count));
                end
            end
        endtask
    endclass

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_in_valid    = 1'b0;
    logic                           o_in_ready;
    logic [pmss_pkg::CMD_W-1:0]     i_command     = pmss_pkg::CMD_ADD;
    logic [pmss_pkg::KEY_W-1:0]     i_key         = '0;
    logic [pmss_pkg::SEL_W-1:0]     i_slot        = '0;
    logic                           o_out_valid;
    logic                           i_out_ready   = 1'b0;
    logic [pmss_pkg::STAT_W-1:0]    o_status;
    logic [pmss_pkg::IDX_W-1:0]     o_slot_index;
    logic [pmss_pkg::ENT_W-1:0]     o_entry_count;

    slot_table_tracker  table_track   = new();
    bit                 quiet         = 1'b0;
    bit                 hold_request  = 1'b0;

    priority_message_slot_store_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_slot        (i_slot),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_entry_count (o_entry_count)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic pmss_pkg::t_cmd make_cmd(input logic [pmss_pkg::CMD_W-1:0] command,
                                                input logic [pmss_pkg::KEY_W-1:0] key,
                                                input logic [pmss_pkg::SEL_W-1:0] slot);
        pmss_pkg::t_cmd c;
        c.command = command;
        c.key     = key;
        c.slot    = slot;
        return c;
    endfunction

    function automatic logic [pmss_pkg::KEY_W-1:0] pick_key();
        logic                        sign;
        logic [pmss_pkg::MAG_W-1:0]  tie_pool [4];
        tie_pool[0] = 15'h3C00;
        tie_pool[1] = 15'h4500;
        tie_pool[2] = 15'h0001;
        tie_pool[3] = 15'h7BFF;
        sign = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0:       return {sign, pmss_pkg::INF_MAG};
            1:       return {sign, pmss_pkg::MAG_W'(pmss_pkg::INF_MAG + $urandom_range(1, 1023))};
            2:       return {sign, {pmss_pkg::MAG_W{1'b0}}};
            3, 4:    return {sign, tie_pool[$urandom_range(0, 3)]};
            default: return pmss_pkg::KEY_W'($urandom);
        endcase
    endfunction

    task automatic send_command(input pmss_pkg::t_cmd c);
        i_in_valid <= 1'b1;
        i_command  <= c.command;
        i_key      <= c.key;
        i_slot     <= c.slot;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        table_track.take_command(c);
    endtask

    task automatic idle_sender(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (table_track.pending() != 0) @(posedge i_clk);
    endtask

    // result channel: check at the falling edge, decide ready at the rising edge
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (o_out_valid && i_out_ready) begin
                table_track.check_result('{o_status, o_slot_index, o_entry_count});
            end
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        bit              filling;
        int unsigned     pick;
        pmss_pkg::t_cmd  c;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_command(make_cmd(pmss_pkg::CMD_GET,    16'h0000, 4'd0));
        send_command(make_cmd(pmss_pkg::CMD_ADD,    16'h7C01, 4'd0));
        send_command(make_cmd(pmss_pkg::CMD_GET,    16'hFFFF, 4'd15));
        send_command(make_cmd(pmss_pkg::CMD_ADD,    16'h0000, 4'd0));
        send_command(make_cmd(pmss_pkg::CMD_ADD,    16'h8000, 4'd0));
        send_command(make_cmd(pmss_pkg::CMD_GET,    16'h0000, 4'd0));
        send_command(make_cmd(pmss_pkg::CMD_ADD,    16'hFC00, 4'd0));
        send_command(make_cmd(pmss_pkg::CMD_ADD,    16'h7C00, 4'd0));
        send_command(make_cmd(pmss_pkg::CMD_GET,    16'h0000, 4'd0));
        send_command(make_cmd(pmss_pkg::CMD_ADD,    16'hFFFF, 4'd15));
        send_command(make_cmd(pmss_pkg::CMD_ADD,    16'h7BFF, 4'd0));
        send_command(make_cmd(pmss_pkg::CMD_ADD,    16'h0001, 4'd0));
        send_command(make_cmd(pmss_pkg::CMD_REMOVE, 16'h0000, 4'd4));
        send_command(make_cmd(pmss_pkg::CMD_GET,    16'h0000, 4'd0));
        send_command(make_cmd(pmss_pkg::CMD_REMOVE, 16'h0000, 4'd4));
        send_command(make_cmd(pmss_pkg::CMD_REMOVE, 16'hFFFF, 4'd15));
        send_command(make_cmd(CMD_UNUSED,           16'hFFFF, 4'd15));
        send_command(make_cmd(pmss_pkg::CMD_REMOVE, 16'h0000, 4'd3));
        send_command(make_cmd(pmss_pkg::CMD_GET,    16'h0000, 4'd0));
        send_command(make_cmd(pmss_pkg::CMD_ADD,    16'h1234, 4'd9));
        send_command(make_cmd(pmss_pkg::CMD_REMOVE, 16'h0000, 4'd0));
        send_command(make_cmd(pmss_pkg::CMD_GET,    16'h0000, 4'd0));
        wait_drained();

        filling = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
                quiet = 1'b1;
            end
            if (n == HOLD_ITEM) begin
                hold_request = 1'b1;
            end
            if (n == DRAIN_ITEM) begin
                wait_drained();
            end
            // flip between filling and draining the table
            if (table_track.live_entries == pmss_pkg::SLOTS && $urandom_range(0, 2) == 0) begin
                filling = 1'b0;
            end else if (table_track.live_entries == 0) begin
                filling = 1'b1;
            end else if ($urandom_range(0, 39) == 0) begin
                filling = !filling;
            end
            pick = $urandom_range(0, 99);
            if (pick >= 92) begin
                c = make_cmd(pmss_pkg::CMD_W'($urandom_range(0, 3)),
                             pmss_pkg::KEY_W'($urandom), pmss_pkg::SEL_W'($urandom));
            end else if (pick < (filling ? 60 : 15)) begin
                c = make_cmd(pmss_pkg::CMD_ADD, pick_key(), pmss_pkg::SEL_W'($urandom));
            end else if (pick < (filling ? 80 : 40)) begin
                c = make_cmd(pmss_pkg::CMD_GET, pmss_pkg::KEY_W'($urandom),
                             pmss_pkg::SEL_W'($urandom));
            end else begin
                c = make_cmd(pmss_pkg::CMD_REMOVE, pmss_pkg::KEY_W'($urandom),
                             pmss_pkg::SEL_W'($urandom));
                if (table_track.live_entries != 0 && $urandom_range(0, 4) != 0) begin
                    c.slot = table_track.pick_occupied();
                end
            end
            if (!quiet && $urandom_range(0, 7) == 0) begin
                idle_sender($urandom_range(1, 16));
            end
            send_command(c);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (table_track.pending() != 0) begin
            table_track.report($sformatf("%0d results never arrived", table_track.pending()));
        end
        if (table_track.error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
